/* src/pbk_pkg.sv */
// Shared types, codes and the button-to-key mapping for the pad key event block.
package pbk_pkg;

	// Input item kinds
	typedef enum logic [1:0] {
		KIND_BUTTON      = 2'd0,
		KIND_NAV         = 2'd1,
		KIND_RELEASE_ALL = 2'd2,
		KIND_UNUSED      = 2'd3
	} kind_t;

	// Key codes and button numbers
	localparam logic [4:0] KEY_ENTER        = 5'd16;
	localparam logic [4:0] KEY_NAV_BASE     = 5'd17;
	localparam logic [4:0] MAX_BUTTON_INDEX = 5'd16;
	localparam logic [4:0] LAST_PAD_KEY     = 5'd15;
	localparam logic [4:0] DPAD_FIRST       = 5'd12;
	localparam logic [4:0] TRIGGER_LEFT     = 5'd6;
	localparam logic [4:0] TRIGGER_RIGHT    = 5'd7;

	// Release-all result limit
	localparam int unsigned COUNT_W = 5;
	localparam logic [COUNT_W-1:0] MAX_RESULTS = 5'd21;

	// Configuration register map
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_DELAY  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_PERIOD = 1'd1;
	localparam logic [CFG_DATA_W-1:0]  DELAY_RESET       = 16'd400;
	localparam logic [CFG_DATA_W-1:0]  PERIOD_RESET      = 16'd120;

	// Controller states
	typedef enum logic {
		ST_IDLE,
		ST_SWEEP
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;
		logic sweep_start;
		logic sweep_step;
	} pbk_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;
		logic sweep_last;
	} pbk_status_t;

	typedef struct packed {
		logic ok;
		logic enter;
	} key_map_t;

	// Mapping of a pressed button; menu mode hides the D-pad and turns triggers into enter
	function automatic key_map_t map_button(logic [4:0] idx, logic game);
		key_map_t m;
		m.ok    = 1'b0;
		m.enter = 1'b0;
		if (idx <= LAST_PAD_KEY) begin
			if (game) begin
				m.ok = 1'b1;
			end else if (idx < DPAD_FIRST) begin
				m.ok    = 1'b1;
				m.enter = (idx == TRIGGER_LEFT) || (idx == TRIGGER_RIGHT);
			end
		end
		return m;
	endfunction

endpackage

/* src/pbk_ctrl.sv */
// Controller state machine: item acceptance and the release-all sweep.
module pbk_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          kind,
	input  pbk_pkg::pbk_status_t status,
	output logic                in_ready,
	output pbk_pkg::pbk_cmd_t   cmd
);

	pbk_pkg::state_t state_q;
	pbk_pkg::state_t state_d;
	logic            accept;

	assign accept = in_valid && in_ready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pbk_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pbk_pkg::ST_IDLE: begin
				if (accept && (kind == pbk_pkg::KIND_RELEASE_ALL)) begin
					state_d = pbk_pkg::ST_SWEEP;
				end
			end
			pbk_pkg::ST_SWEEP: begin
				if (status.out_free && status.sweep_last) begin
					state_d = pbk_pkg::ST_IDLE;
				end
			end
			default: state_d = pbk_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready        = 1'b0;
		cmd.accept      = 1'b0;
		cmd.sweep_start = 1'b0;
		cmd.sweep_step  = 1'b0;
		unique case (state_q)
			pbk_pkg::ST_IDLE: begin
				in_ready        = status.out_free;
				cmd.accept      = in_valid && status.out_free;
				cmd.sweep_start = in_valid && status.out_free &&
					(kind == pbk_pkg::KIND_RELEASE_ALL);
			end
			pbk_pkg::ST_SWEEP: begin
				cmd.sweep_step = status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

/* src/pbk_datapath.sv */
// Datapath: held flags, repeat deadlines, config registers, sweep walker, result register.
module pbk_datapath #(
	parameter int unsigned NUM_BUTTONS    = 17,
	parameter int unsigned NUM_DIRECTIONS = 4,
	parameter int unsigned TIME_BITS      = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pbk_pkg::pbk_cmd_t                  cmd,
	output pbk_pkg::pbk_status_t               status,
	input  logic                               cfg_we,
	input  logic [pbk_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [pbk_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [1:0]                         kind,
	input  logic [4:0]                         button_index,
	input  logic                               level_down,
	input  logic                               game_mode,
	input  logic [1:0]                         nav_slot,
	input  logic [31:0]                        now_ms,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic [4:0]                         key_code,
	output logic                               pressed,
	output logic                               last_event
);

	localparam int unsigned BW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
	localparam int unsigned DW = (NUM_DIRECTIONS > 1) ? $clog2(NUM_DIRECTIONS) : 1;
	localparam int unsigned EW = NUM_BUTTONS + NUM_DIRECTIONS;
	localparam int unsigned TW = $clog2(EW);

	// Configuration
	logic [pbk_pkg::CFG_DATA_W-1:0] delay_q;
	logic [pbk_pkg::CFG_DATA_W-1:0] period_q;

	// Per-button and per-direction state
	logic [NUM_BUTTONS-1:0]    held_q;
	logic [NUM_BUTTONS-1:0]    enter_q;
	logic [NUM_DIRECTIONS-1:0] dir_held_q;
	logic [TIME_BITS-1:0]      deadline_q [NUM_DIRECTIONS];

	// Sweep walker
	logic [TW-1:0]                   walk_idx_q;
	logic [pbk_pkg::COUNT_W-1:0]     count_q;

	// Result register
	logic       out_valid_q;
	logic [4:0] key_q;
	logic       pressed_q;
	logic       last_q;

	// Item decode
	logic                 out_free;
	logic [BW-1:0]        bi;
	logic [DW-1:0]        di;
	logic                 btn_ok;
	logic                 slot_ok;
	logic                 is_btn_item;
	logic                 is_nav_item;
	pbk_pkg::key_map_t    map;
	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] since;
	logic                 reached;
	logic [4:0]           nav_key;

	// Item events
	logic       btn_press;
	logic       btn_release;
	logic       nav_press;
	logic       nav_repeat;
	logic       nav_release;
	logic       item_ev;
	logic [4:0] item_key;
	logic       item_pressed;

	// Sweep step
	logic [EW-1:0] all_held;
	logic          walk_is_btn;
	logic [TW-1:0] dir_off;
	logic [BW-1:0] walk_bi;
	logic [DW-1:0] walk_di;
	logic          walk_held;
	logic          rest_any;
	logic [4:0]    walk_key;
	logic          walk_emit;

	assign out_free = !out_valid_q || out_ready;

	// Decode of a button or navigation item
	always_comb begin
		bi          = button_index[BW-1:0];
		di          = DW'(nav_slot);
		btn_ok      = ({1'b0, button_index} < 6'(NUM_BUTTONS)) &&
			(button_index <= pbk_pkg::MAX_BUTTON_INDEX);
		slot_ok     = (4'(nav_slot) < 4'(NUM_DIRECTIONS));
		is_btn_item = cmd.accept && (kind == pbk_pkg::KIND_BUTTON) && btn_ok;
		is_nav_item = cmd.accept && (kind == pbk_pkg::KIND_NAV) && slot_ok;
		map         = pbk_pkg::map_button(button_index, game_mode);
		now_t       = TIME_BITS'(now_ms);
		since       = now_t - deadline_q[di];
		reached     = !since[TIME_BITS-1];
		nav_key     = pbk_pkg::KEY_NAV_BASE + 5'(nav_slot);
	end

	// Events caused by an item
	always_comb begin
		btn_press    = is_btn_item && level_down && !held_q[bi] && map.ok;
		btn_release  = is_btn_item && !level_down && held_q[bi];
		nav_press    = is_nav_item && level_down && !dir_held_q[di];
		nav_repeat   = is_nav_item && level_down && dir_held_q[di] && reached;
		nav_release  = is_nav_item && !level_down && dir_held_q[di];
		item_ev      = btn_press || btn_release || nav_press || nav_repeat || nav_release;
		item_pressed = btn_press || nav_press || nav_repeat;
		if (btn_press) begin
			item_key = map.enter ? pbk_pkg::KEY_ENTER : button_index;
		end else if (btn_release) begin
			item_key = enter_q[bi] ? pbk_pkg::KEY_ENTER : button_index;
		end else begin
			item_key = nav_key;
		end
	end

	// Sweep entry selection: buttons first, then directions
	always_comb begin
		all_held    = {dir_held_q, held_q};
		walk_is_btn = walk_idx_q < TW'(NUM_BUTTONS);
		dir_off     = walk_idx_q - TW'(NUM_BUTTONS);
		walk_bi     = walk_idx_q[BW-1:0];
		walk_di     = dir_off[DW-1:0];
		walk_held   = all_held[walk_idx_q];
		rest_any    = 1'b0;
		for (int i = 0; i < EW; i++) begin
			if ((TW'(i) > walk_idx_q) && all_held[i]) begin
				rest_any = 1'b1;
			end
		end
		if (walk_is_btn) begin
			walk_key = enter_q[walk_bi] ? pbk_pkg::KEY_ENTER : 5'(walk_idx_q);
		end else begin
			walk_key = pbk_pkg::KEY_NAV_BASE + 5'(dir_off);
		end
		walk_emit = cmd.sweep_step && walk_held && (count_q < pbk_pkg::MAX_RESULTS);
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q  <= pbk_pkg::DELAY_RESET;
			period_q <= pbk_pkg::PERIOD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pbk_pkg::REG_REPEAT_DELAY:  delay_q  <= cfg_data;
				pbk_pkg::REG_REPEAT_PERIOD: period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Held flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= '0;
			dir_held_q <= '0;
		end else begin
			if (btn_press) begin
				held_q[bi] <= 1'b1;
			end
			if (btn_release) begin
				held_q[bi] <= 1'b0;
			end
			if (nav_press) begin
				dir_held_q[di] <= 1'b1;
			end
			if (nav_release) begin
				dir_held_q[di] <= 1'b0;
			end
			if (cmd.sweep_step) begin
				if (walk_is_btn) begin
					held_q[walk_bi] <= 1'b0;
				end else begin
					dir_held_q[walk_di] <= 1'b0;
				end
			end
		end
	end

	// Remembered enter mapping and repeat deadlines
	always_ff @(posedge clk) begin
		if (btn_press) begin
			enter_q[bi] <= map.enter;
		end
		if (nav_press) begin
			deadline_q[di] <= now_t + TIME_BITS'(delay_q);
		end else if (nav_repeat) begin
			deadline_q[di] <= now_t + TIME_BITS'(period_q);
		end
		if (cmd.sweep_start) begin
			for (int i = 0; i < NUM_DIRECTIONS; i++) begin
				deadline_q[i] <= '0;
			end
		end
	end

	// Sweep walker and result count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_idx_q <= '0;
			count_q    <= '0;
		end else if (cmd.sweep_start) begin
			walk_idx_q <= '0;
			count_q    <= '0;
		end else if (cmd.sweep_step) begin
			walk_idx_q <= walk_idx_q + 1'b1;
			if (walk_emit) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_ev || walk_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (item_ev) begin
			key_q     <= item_key;
			pressed_q <= item_pressed;
			last_q    <= 1'b1;
		end else if (walk_emit) begin
			key_q     <= walk_key;
			pressed_q <= 1'b0;
			last_q    <= !rest_any || (count_q == pbk_pkg::MAX_RESULTS - 1'b1);
		end
	end

	assign status.out_free   = out_free;
	assign status.sweep_last = (walk_idx_q == TW'(EW - 1));

	assign out_valid  = out_valid_q;
	assign key_code   = key_q;
	assign pressed    = pressed_q;
	assign last_event = last_q;

endmodule

/* src/pad_button_key_events_autorepeat.sv */
// Top level of the gamepad key event generator with navigation autorepeat.
//
//  channel   signals                        payload
//  in        in_valid / in_ready            kind, button_index, level_down, game_mode,
//                                           nav_slot, now_ms
//  out       out_valid / out_ready          key_code, pressed, last_event
//  cfg       cfg_we (no wait)               cfg_index, cfg_data
//
// Button and navigation items leave their result in the output register the cycle after
// they are taken, and a new item is taken in the cycle that result leaves.
// Release-all walks one entry per cycle through NUM_BUTTONS + NUM_DIRECTIONS entries
// while the output side does not stall.
// Reset clears all held flags, restores the registers and leaves the output empty.
// While the output register holds an untaken result, in_ready stays low.
module pad_button_key_events_autorepeat #(
	parameter int unsigned NUM_BUTTONS    = 17,
	parameter int unsigned NUM_DIRECTIONS = 4,
	parameter int unsigned TIME_BITS      = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pbk_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pbk_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      kind,
	input  logic [4:0]                      button_index,
	input  logic                            level_down,
	input  logic                            game_mode,
	input  logic [1:0]                      nav_slot,
	input  logic [31:0]                     now_ms,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [4:0]                      key_code,
	output logic                            pressed,
	output logic                            last_event
);

	pbk_pkg::pbk_cmd_t    cmd;
	pbk_pkg::pbk_status_t status;

	pbk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.status   (status),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	pbk_datapath #(
		.NUM_BUTTONS    (NUM_BUTTONS),
		.NUM_DIRECTIONS (NUM_DIRECTIONS),
		.TIME_BITS      (TIME_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.kind         (kind),
		.button_index (button_index),
		.level_down   (level_down),
		.game_mode    (game_mode),
		.nav_slot     (nav_slot),
		.now_ms       (now_ms),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.key_code     (key_code),
		.pressed      (pressed),
		.last_event   (last_event)
	);

endmodule

/* src/pbk_checker.sv */
// Port-level checker for the pad key event block, bound to the top level.
module pbk_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] kind,
	input logic [4:0] button_index,
	input logic       out_valid,
	input logic       out_ready,
	input logic [4:0] key_code,
	input logic       pressed,
	input logic       last_event
);

	// A stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(key_code) &&
			$stable(pressed) && $stable(last_event))
		else $error("stalled result changed");

	// A new transaction is taken only when the output register can take its result
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid || out_ready)
		else $error("input taken while output is blocked");

	// Unused kinds and out-of-range buttons produce nothing
	a_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && ((kind == pbk_pkg::KIND_UNUSED) ||
			((kind == pbk_pkg::KIND_BUTTON) && (button_index > pbk_pkg::MAX_BUTTON_INDEX)))
		|=> !out_valid)
		else $error("ignored transaction produced a result");

	// Release-all blocks new input while it sweeps
	a_sweep_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (kind == pbk_pkg::KIND_RELEASE_ALL) |=> !in_ready)
		else $error("input taken during release-all sweep");

	// Taking release-all leaves the output empty until the sweep starts emitting
	a_sweep_release: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (kind == pbk_pkg::KIND_RELEASE_ALL) |=> !out_valid)
		else $error("release-all result appeared before the sweep");

endmodule

bind pad_button_key_events_autorepeat pbk_checker u_pbk_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.kind         (kind),
	.button_index (button_index),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.key_code     (key_code),
	.pressed      (pressed),
	.last_event   (last_event)
);

/* bench/tb_top.sv */
// Self-checking testbench for the pad key event generator with navigation autorepeat.
`timescale 1ns / 1ps

module tb_top;

	localparam int NUM_BTN       = 17;
	localparam int NUM_DIR       = 4;
	localparam int EVENT_CAP     = pbk_pkg::MAX_RESULTS;
	localparam int SETTLE_CYCLES = 30;
	localparam int LIMIT_CYCLES  = 500000;
	localparam int PHASE_ITEMS   = 125;
	localparam logic [31:0] START_MS = 32'hFFFF_FF00;

	// One input transaction
	typedef struct {
		pbk_pkg::kind_t kind;
		logic [4:0]     bidx;
		logic           down;
		logic           game;
		logic [1:0]     slot;
		logic [31:0]    now;
	} pad_item_t;

	// One key event
	typedef struct packed {
		logic [4:0] key_code;
		logic       pressed;
		logic       last_event;
	} key_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [pbk_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [pbk_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] kind = '0;
	logic [4:0] button_index = '0;
	logic level_down = 1'b0;
	logic game_mode = 1'b0;
	logic [1:0] nav_slot = '0;
	logic [31:0] now_ms = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [4:0] key_code;
	logic pressed;
	logic last_event;

	pad_button_key_events_autorepeat uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.button_index(button_index),
		.level_down(level_down),
		.game_mode(game_mode),
		.nav_slot(nav_slot),
		.now_ms(now_ms),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.key_code(key_code),
		.pressed(pressed),
		.last_event(last_event)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	pad_item_t  pending_items[$];
	key_event_t expected_events[$];
	pad_item_t  next_item;
	logic       in_fire = 1'b0;
	int         idle_in_pct = 0;
	int         stall_pct = 0;
	int         cycle_count = 0;
	int         errors = 0;
	int         items_taken = 0;
	int         events_checked = 0;
	logic [31:0] clock_ms;

	// Predictor state
	logic        btn_held [NUM_BTN];
	logic [4:0]  btn_key [NUM_BTN];
	logic        nav_down [NUM_DIR];
	logic [31:0] nav_deadline [NUM_DIR];
	logic [15:0] delay_ms;
	logic [15:0] period_ms;

	function automatic void reset_predictor();
		for (int i = 0; i < NUM_BTN; i++) begin
			btn_held[i] = 1'b0;
			btn_key[i]  = '0;
		end
		for (int i = 0; i < NUM_DIR; i++) begin
			nav_down[i]     = 1'b0;
			nav_deadline[i] = '0;
		end
		delay_ms  = pbk_pkg::DELAY_RESET;
		period_ms = pbk_pkg::PERIOD_RESET;
	endfunction

	// {mapped, key} for a pressed button
	function automatic logic [5:0] button_key(logic [4:0] idx, logic game);
		if (idx > pbk_pkg::LAST_PAD_KEY)
			return '0;
		if (!game && idx >= pbk_pkg::DPAD_FIRST)
			return '0;
		if (!game && (idx == pbk_pkg::TRIGGER_LEFT || idx == pbk_pkg::TRIGGER_RIGHT))
			return {1'b1, pbk_pkg::KEY_ENTER};
		return {1'b1, idx};
	endfunction

	// Update held state and queue the key events one transaction produces
	function automatic void predict_key_events(pad_item_t it);
		key_event_t evs [EVENT_CAP];
		int n;
		logic [5:0] map;
		logic [31:0] diff;
		logic [4:0] nk;
		n = 0;
		case (it.kind)
			pbk_pkg::KIND_BUTTON: begin
				if (it.bidx <= pbk_pkg::MAX_BUTTON_INDEX) begin
					if (it.down) begin
						map = button_key(it.bidx, it.game);
						if (!btn_held[it.bidx] && map[5]) begin
							btn_held[it.bidx] = 1'b1;
							btn_key[it.bidx]  = map[4:0];
							evs[n] = '{key_code: map[4:0], pressed: 1'b1,
								last_event: 1'b0};
							n++;
						end
					end else if (btn_held[it.bidx]) begin
						evs[n] = '{key_code: btn_key[it.bidx], pressed: 1'b0,
							last_event: 1'b0};
						n++;
						btn_held[it.bidx] = 1'b0;
						btn_key[it.bidx]  = '0;
					end
				end
			end
			pbk_pkg::KIND_NAV: begin
				nk   = pbk_pkg::KEY_NAV_BASE + 5'(it.slot);
				diff = it.now - nav_deadline[it.slot];
				if (!it.down) begin
					if (nav_down[it.slot]) begin
						nav_down[it.slot] = 1'b0;
						evs[n] = '{key_code: nk, pressed: 1'b0, last_event: 1'b0};
						n++;
					end
				end else if (!nav_down[it.slot]) begin
					nav_down[it.slot]     = 1'b1;
					nav_deadline[it.slot] = it.now + 32'(delay_ms);
					evs[n] = '{key_code: nk, pressed: 1'b1, last_event: 1'b0};
					n++;
				end else if (!diff[31]) begin
					// deadline reached by the sign of the wrapped difference
					nav_deadline[it.slot] = it.now + 32'(period_ms);
					evs[n] = '{key_code: nk, pressed: 1'b1, last_event: 1'b0};
					n++;
				end
			end
			pbk_pkg::KIND_RELEASE_ALL: begin
				for (int i = 0; i < NUM_BTN; i++) begin
					if (btn_held[i] && n < EVENT_CAP) begin
						evs[n] = '{key_code: btn_key[i], pressed: 1'b0, last_event: 1'b0};
						n++;
					end
					btn_held[i] = 1'b0;
					btn_key[i]  = '0;
				end
				for (int i = 0; i < NUM_DIR; i++) begin
					if (nav_down[i] && n < EVENT_CAP) begin
						evs[n] = '{key_code: pbk_pkg::KEY_NAV_BASE + 5'(i), pressed: 1'b0,
							last_event: 1'b0};
						n++;
					end
					nav_down[i]     = 1'b0;
					nav_deadline[i] = '0;
				end
			end
			default: ;
		endcase
		for (int i = 0; i < n; i++) begin
			evs[i].last_event = (i == n - 1);
			expected_events.push_back(evs[i]);
		end
	endfunction

	// Driver: presents queued transactions, holds them until taken
	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= idle_in_pct) begin
				next_item = pending_items.pop_front();
				in_valid     <= 1'b1;
				kind         <= next_item.kind;
				button_index <= next_item.bidx;
				level_down   <= next_item.down;
				game_mode    <= next_item.game;
				nav_slot     <= next_item.slot;
				now_ms       <= next_item.now;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Monitor: checks results, tracks register writes and predicts accepted items
	always @(posedge clk) begin
		key_event_t want;
		cycle_count = cycle_count + 1;
		in_fire <= in_valid && in_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_events.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("ERROR: unexpected event key=%0d pressed=%0d last=%0d",
							key_code, pressed, last_event);
				end else begin
					want = expected_events.pop_front();
					events_checked++;
					if (key_code !== want.key_code || pressed !== want.pressed ||
						last_event !== want.last_event) begin
						errors++;
						if (errors <= 10) begin
							$display("ERROR: event mismatch exp key=%0d pressed=%0d last=%0d,",
								want.key_code, want.pressed, want.last_event);
							$display("       got key=%0d pressed=%0d last=%0d",
								key_code, pressed, last_event);
						end
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == pbk_pkg::REG_REPEAT_DELAY)
					delay_ms = cfg_data;
				else if (cfg_index == pbk_pkg::REG_REPEAT_PERIOD)
					period_ms = cfg_data;
			end
			if (in_valid && in_ready) begin
				items_taken++;
				predict_key_events('{kind: pbk_pkg::kind_t'(kind), bidx: button_index,
					down: level_down, game: game_mode, slot: nav_slot, now: now_ms});
			end
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < LIMIT_CYCLES)
			@(posedge clk);
		$display("pad_button_key_events_autorepeat test failed");
		$finish;
	end

	task automatic add_item(pbk_pkg::kind_t k, logic [4:0] b, logic d, logic g,
		logic [1:0] s, logic [31:0] t);
		pending_items.push_back('{kind: k, bidx: b, down: d, game: g, slot: s, now: t});
	endtask

	task automatic write_reg(logic [pbk_pkg::CFG_INDEX_W-1:0] idx,
		logic [pbk_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until everything is sent and answered, then let a release-all sweep finish
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || in_valid || expected_events.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly small steps, sometimes past the repeat deadlines, sometimes anywhere
	task automatic advance_clock();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			clock_ms = clock_ms + $urandom_range(60);
		else if (r < 92)
			clock_ms = clock_ms + $urandom_range(2 * (int'(delay_ms) + int'(period_ms)) + 2);
		else
			clock_ms = $urandom();
	endtask

	// Every mappable button and every direction held, then release all
	task automatic add_hold_all();
		for (int i = 0; i <= pbk_pkg::LAST_PAD_KEY; i++)
			add_item(pbk_pkg::KIND_BUTTON, 5'(i), 1'b1, 1'b1, 2'($urandom_range(3)),
				clock_ms);
		for (int i = 0; i < NUM_DIR; i++) begin
			advance_clock();
			add_item(pbk_pkg::KIND_NAV, 5'($urandom_range(31)), 1'b1,
				1'($urandom_range(1)), 2'(i), clock_ms);
		end
		add_item(pbk_pkg::KIND_RELEASE_ALL, 5'($urandom_range(31)), 1'($urandom_range(1)),
			1'($urandom_range(1)), 2'($urandom_range(3)), $urandom());
	endtask

	// One random transaction; returns 1 when the block does not ignore it
	task automatic add_random_item(output bit counted);
		pad_item_t it;
		int r;
		advance_clock();
		it.bidx = ($urandom_range(99) < 90) ? 5'($urandom_range(16)) : 5'($urandom_range(31));
		it.down = 1'($urandom_range(1));
		it.game = 1'($urandom_range(1));
		it.slot = 2'($urandom_range(3));
		it.now  = clock_ms;
		r = $urandom_range(99);
		if (r < 46) begin
			it.kind = pbk_pkg::KIND_BUTTON;
		end else if (r < 92) begin
			it.kind = pbk_pkg::KIND_NAV;
			it.down = ($urandom_range(99) < 75);
		end else if (r < 96) begin
			it.kind = pbk_pkg::KIND_RELEASE_ALL;
		end else begin
			it.kind = pbk_pkg::KIND_UNUSED;
		end
		pending_items.push_back(it);
		counted = !(it.kind == pbk_pkg::KIND_UNUSED ||
			(it.kind == pbk_pkg::KIND_BUTTON && it.bidx > pbk_pkg::MAX_BUTTON_INDEX));
	endtask

	task automatic run_phase(int in_pct, int out_pct, logic [15:0] d, logic [15:0] p);
		int counted;
		bit c;
		idle_in_pct = in_pct;
		stall_pct   = out_pct;
		write_reg(pbk_pkg::REG_REPEAT_DELAY, d);
		write_reg(pbk_pkg::REG_REPEAT_PERIOD, p);
		add_hold_all();
		counted = 21;
		while (counted < PHASE_ITEMS) begin
			if ($urandom_range(99) < 3) begin
				add_hold_all();
				counted += 21;
			end else begin
				add_random_item(c);
				counted += c;
			end
		end
		wait_drained();
	endtask

	initial begin
		reset_predictor();
		clock_ms = START_MS;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed checks at the reset register values, starting just before the wrap
		// press A, press while held, menu trigger gives enter, game trigger
		add_item(pbk_pkg::KIND_BUTTON, 5'd0, 1'b1, 1'b1, 2'd3, START_MS);
		add_item(pbk_pkg::KIND_BUTTON, 5'd0, 1'b1, 1'b0, 2'd0, START_MS);
		add_item(pbk_pkg::KIND_BUTTON, pbk_pkg::TRIGGER_LEFT, 1'b1, 1'b0, 2'd0, START_MS);
		add_item(pbk_pkg::KIND_BUTTON, pbk_pkg::TRIGGER_RIGHT, 1'b1, 1'b1, 2'd0, START_MS);
		// menu D-pad gives nothing, last pad key, guide unmapped, out of range
		add_item(pbk_pkg::KIND_BUTTON, pbk_pkg::DPAD_FIRST, 1'b1, 1'b0, 2'd0, START_MS);
		add_item(pbk_pkg::KIND_BUTTON, pbk_pkg::LAST_PAD_KEY, 1'b1, 1'b1, 2'd0, START_MS);
		add_item(pbk_pkg::KIND_BUTTON, pbk_pkg::MAX_BUTTON_INDEX, 1'b1, 1'b1, 2'd0,
			START_MS);
		add_item(pbk_pkg::KIND_BUTTON, 5'd31, 1'b1, 1'b1, 2'd3, '1);
		// remembered enter on release, release while not held
		add_item(pbk_pkg::KIND_BUTTON, pbk_pkg::TRIGGER_LEFT, 1'b0, 1'b1, 2'd0, START_MS);
		add_item(pbk_pkg::KIND_BUTTON, 5'd3, 1'b0, 1'b1, 2'd0, START_MS);
		// left down, just short, first repeat across the wrap, later repeat
		add_item(pbk_pkg::KIND_NAV, 5'd0, 1'b1, 1'b0, 2'd0, START_MS);
		add_item(pbk_pkg::KIND_NAV, 5'd0, 1'b1, 1'b0, 2'd0, START_MS + 32'd399);
		add_item(pbk_pkg::KIND_NAV, 5'd0, 1'b1, 1'b0, 2'd0, START_MS + 32'd400);
		add_item(pbk_pkg::KIND_NAV, 5'd0, 1'b1, 1'b1, 2'd0, START_MS + 32'd520);
		// down held and released, right and up held, time went back
		add_item(pbk_pkg::KIND_NAV, 5'd0, 1'b1, 1'b1, 2'd3, START_MS + 32'd520);
		add_item(pbk_pkg::KIND_NAV, 5'd0, 1'b0, 1'b1, 2'd3, START_MS + 32'd530);
		add_item(pbk_pkg::KIND_NAV, 5'd0, 1'b1, 1'b0, 2'd1, START_MS + 32'd530);
		add_item(pbk_pkg::KIND_NAV, 5'd0, 1'b1, 1'b0, 2'd2, START_MS + 32'd540);
		add_item(pbk_pkg::KIND_NAV, 5'd0, 1'b1, 1'b0, 2'd2, START_MS - 32'd5000);
		// unused kind, release all, release all with nothing held
		add_item(pbk_pkg::KIND_UNUSED, 5'd5, 1'b1, 1'b1, 2'd1, START_MS);
		add_item(pbk_pkg::KIND_RELEASE_ALL, 5'd0, 1'b0, 1'b0, 2'd0, START_MS);
		add_item(pbk_pkg::KIND_RELEASE_ALL, 5'd31, 1'b1, 1'b1, 2'd3, '1);
		// release in the other mode, direction release while not held
		add_item(pbk_pkg::KIND_BUTTON, 5'd11, 1'b1, 1'b0, 2'd0, START_MS);
		add_item(pbk_pkg::KIND_BUTTON, 5'd11, 1'b0, 1'b1, 2'd0, START_MS);
		add_item(pbk_pkg::KIND_NAV, 5'd0, 1'b0, 1'b0, 2'd0, START_MS);
		wait_drained();

		// Random phases across register extremes and idling patterns
		clock_ms = $urandom();
		run_phase(0, 0, 16'd0, 16'd0);
		run_phase(72, 0, 16'hFFFF, 16'hFFFF);
		run_phase(0, 72, 16'($urandom_range(1000)), 16'd1);
		run_phase(9, 9, 16'($urandom()), 16'($urandom_range(1, 65535)));

		if (expected_events.size() != 0)
			errors += expected_events.size();
		$display("Run covered %0d input transactions and %0d key events", items_taken,
			events_checked);
		$display("over directed cases, four register settings and four idling patterns");
		if (errors == 0) begin
			$display("pad_button_key_events_autorepeat test passed");
		end else begin
			$display("%0d mismatches", errors);
			$display("pad_button_key_events_autorepeat test failed");
		end
		$finish;
	end

endmodule
